FILE: hw/rtl/cstp_pkg.sv
`timescale 1ns / 1ps
package cstp_pkg;

    localparam int MAX_STEMS_DEF = 96;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam int APB_AW  = 4;

    localparam logic [1:0] REG_MASTER_COUNT    = 2'd0;
    localparam logic [1:0] REG_TYPE1_NUMBERS   = 2'd1;
    localparam logic [1:0] REG_STOP_AT_ENDCHAR = 2'd2;

    localparam logic [7:0] OP_HSTEM     = 8'd1;
    localparam logic [7:0] OP_VSTEM     = 8'd3;
    localparam logic [7:0] OP_ESCAPE    = 8'd12;
    localparam logic [7:0] OP_ENDCHAR   = 8'd14;
    localparam logic [7:0] OP_BLEND     = 8'd16;
    localparam logic [7:0] OP_HSTEMHM   = 8'd18;
    localparam logic [7:0] OP_HINTMASK  = 8'd19;
    localparam logic [7:0] OP_CNTRMASK  = 8'd20;
    localparam logic [7:0] OP_VSTEMHM   = 8'd23;
    localparam logic [7:0] OP_SHORTINT  = 8'd28;
    localparam logic [7:0] NUM_SMALL_LO = 8'd32;
    localparam logic [7:0] NUM_SMALL_HI = 8'd246;
    localparam logic [7:0] NUM_BIAS     = 8'd139;
    localparam logic [7:0] NUM_POS_LO   = 8'd247;
    localparam logic [7:0] NUM_NEG_LO   = 8'd251;
    localparam logic [7:0] NUM_LONG     = 8'd255;
    localparam logic [7:0] ESC_MAX      = 8'd38;
    localparam logic [10:0] NUM_OFFSET  = 11'd108;

    typedef enum logic [1:0] {
        PH_START,
        PH_NUM,
        PH_ESC,
        PH_MASK
    } t_phase;

    typedef enum logic [2:0] {
        CLS_SMALL,
        CLS_LEAD,
        CLS_ESC,
        CLS_MASK,
        CLS_BLEND,
        CLS_ENDCHAR,
        CLS_STEM,
        CLS_OTHER
    } t_cls;

    typedef enum logic [2:0] {
        KIND_NUMBER   = 3'd0,
        KIND_OPERATOR = 3'd1,
        KIND_ESCAPED  = 3'd2,
        KIND_MASK     = 3'd3,
        KIND_UNKNOWN  = 3'd4,
        KIND_TRUNC    = 3'd5
    } t_kind;

    typedef struct packed {
        logic [7:0]        data;
        logic              last;
        t_cls              cls;
        logic signed [7:0] small_val;
        logic [2:0]        num_len;
        logic              esc_known;
    } t_cls_item;

endpackage

FILE: hw/rtl/cstp_front.sv
`timescale 1ns / 1ps
module cstp_front (
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] data_byte
    input  logic                  i_s_tlast,   // last_byte
    input  logic                  i_q_full,
    output logic                  o_push,
    output cstp_pkg::t_cls_item   o_item
);
    import cstp_pkg::*;

    logic [7:0] b;

    assign b          = i_s_tdata;
    assign o_s_tready = !i_q_full && i_rst_n;
    assign o_push     = i_s_tvalid && !i_q_full && i_rst_n;

    always_comb begin
        o_item.data      = b;
        o_item.last      = i_s_tlast;
        o_item.small_val = b - NUM_BIAS;
        o_item.esc_known = (b <= ESC_MAX);
        if (b == NUM_LONG) begin
            o_item.num_len = 3'd4;
        end else if (b == OP_SHORTINT) begin
            o_item.num_len = 3'd2;
        end else begin
            o_item.num_len = 3'd1;
        end
        priority if (b >= NUM_SMALL_LO && b <= NUM_SMALL_HI) begin
            o_item.cls = CLS_SMALL;
        end else if (b >= NUM_POS_LO || b == OP_SHORTINT) begin
            o_item.cls = CLS_LEAD;
        end else if (b == OP_ESCAPE) begin
            o_item.cls = CLS_ESC;
        end else if (b == OP_HINTMASK || b == OP_CNTRMASK) begin
            o_item.cls = CLS_MASK;
        end else if (b == OP_BLEND) begin
            o_item.cls = CLS_BLEND;
        end else if (b == OP_ENDCHAR) begin
            o_item.cls = CLS_ENDCHAR;
        end else if (b == OP_HSTEM || b == OP_VSTEM || b == OP_HSTEMHM || b == OP_VSTEMHM) begin
            o_item.cls = CLS_STEM;
        end else begin
            o_item.cls = CLS_OTHER;
        end
    end

endmodule

FILE: hw/rtl/cstp_queue.sv
`timescale 1ns / 1ps
module cstp_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  cstp_pkg::t_cls_item   i_item,
    output logic                  o_full,
    output logic                  o_valid,
    input  logic                  i_pop,
    output cstp_pkg::t_cls_item   o_item
);
    import cstp_pkg::*;

    t_cls_item       r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, n_wr;
    logic [Q_AW-1:0] r_rd, n_rd;
    logic [Q_AW:0]   r_count, n_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr    = i_push ? r_wr + 1'b1 : r_wr;
        n_rd    = i_pop  ? r_rd + 1'b1 : r_rd;
        n_count = r_count + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: hw/rtl/cstp_back.sv
`timescale 1ns / 1ps
module cstp_back #(
    parameter int MAX_STEMS = cstp_pkg::MAX_STEMS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  cstp_pkg::t_cls_item   i_item,
    output logic                  o_pop,
    input  logic [4:0]            i_master_count,
    input  logic                  i_type1_numbers,
    input  logic                  i_stop_at_endchar,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [39:0]           o_m_tdata,   // [31:0] token_value, [38:32] stem_count
    output logic [3:0]            o_m_tuser,   // [2:0] token_kind, [3] is_fixed
    output logic                  o_m_tlast    // end_of_glyph
);
    import cstp_pkg::*;

    localparam int STEM_W = $clog2(MAX_STEMS + 1);
    localparam int MASK_N = (MAX_STEMS + 7) / 8;
    localparam int CNT_W  = $clog2(MASK_N + 1);
    localparam int PEND_W = (CNT_W > 3) ? CNT_W : 3;

    t_phase             r_phase, n_phase, w_phase;
    logic [PEND_W-1:0]  r_pend, n_pend, w_pend;
    logic [31:0]        r_coll, n_coll, w_coll;
    logic [7:0]         r_lead, n_lead, w_lead;
    logic [STEM_W-1:0]  r_stems, n_stems, w_stems;
    logic signed [15:0] r_args, n_args, w_args;
    logic signed [7:0]  r_lsn, n_lsn, w_lsn;

    logic               r_out_valid;
    t_kind              r_kind;
    logic [31:0]        r_value;
    logic               r_fixed;
    logic [6:0]         r_stem_out;
    logic               r_end;

    logic               advance;
    logic [7:0]         b;
    logic [31:0]        shift_coll;
    logic [15:0]        stem_sum;
    logic [STEM_W-1:0]  stems_taken;
    logic [STEM_W:0]    stem_plus;
    logic [PEND_W-1:0]  mask_k;
    logic signed [15:0] args_inc;
    logic [4:0]         mm1;
    logic signed [13:0] prod;
    logic signed [17:0] blend_diff;
    logic signed [15:0] args_blend;
    logic               end_glyph;

    logic               res_valid;
    t_kind              res_kind;
    logic [31:0]        res_value;
    logic               res_fixed;
    logic [1:0]         lead_off;
    logic [10:0]        mag;

    assign b       = i_item.data;
    assign advance = !r_out_valid || i_m_tready;
    assign o_pop   = i_valid && advance;

    // stem, argument and blend arithmetic
    always_comb begin
        shift_coll  = {r_coll[23:0], b};
        stem_sum    = 16'(r_stems) + ((r_args > 16'sd0) ? {1'b0, r_args[15:1]} : 16'd0);
        stems_taken = (stem_sum > 16'(MAX_STEMS)) ? STEM_W'(MAX_STEMS) : STEM_W'(stem_sum);
        stem_plus   = {1'b0, stems_taken} + (STEM_W+1)'(7);
        mask_k      = PEND_W'(stem_plus >> 3);
        args_inc    = (r_args != 16'sh7fff) ? r_args + 16'sd1 : r_args;
        mm1         = (i_master_count == 5'd0) ? 5'd0 : i_master_count - 5'd1;
        prod        = r_lsn * $signed({1'b0, mm1});
        blend_diff  = 18'(r_args) - 18'(prod) - 18'sd1;
        if (blend_diff < -18'sd32768) begin
            args_blend = -16'sd32768;
        end else if (blend_diff > 18'sd32767) begin
            args_blend = 16'sh7fff;
        end else begin
            args_blend = 16'(blend_diff);
        end
    end

    // next state
    always_comb begin
        w_phase   = r_phase;
        w_pend    = r_pend;
        w_coll    = r_coll;
        w_lead    = r_lead;
        w_stems   = r_stems;
        w_args    = r_args;
        w_lsn     = r_lsn;
        end_glyph = i_item.last;
        unique case (r_phase)
            PH_START: begin
                unique case (i_item.cls)
                    CLS_SMALL: begin
                        w_lsn  = i_item.small_val;
                        w_args = args_inc;
                    end
                    CLS_LEAD: begin
                        w_lead  = b;
                        w_coll  = '0;
                        w_pend  = PEND_W'(i_item.num_len);
                        w_phase = PH_NUM;
                    end
                    CLS_ESC: begin
                        w_lead  = b;
                        w_phase = PH_ESC;
                    end
                    CLS_MASK: begin
                        w_stems = stems_taken;
                        w_args  = '0;
                        if (mask_k != '0) begin
                            w_lead  = b;
                            w_pend  = mask_k;
                            w_phase = PH_MASK;
                        end
                    end
                    CLS_BLEND: begin
                        w_args = args_blend;
                    end
                    CLS_ENDCHAR: begin
                        end_glyph = i_item.last || i_stop_at_endchar;
                    end
                    CLS_STEM: begin
                        w_stems = stems_taken;
                        w_args  = '0;
                    end
                    CLS_OTHER: begin
                        w_args = '0;
                    end
                    default: begin
                        w_args = '0;
                    end
                endcase
            end
            PH_NUM: begin
                w_coll = shift_coll;
                w_pend = r_pend - 1'b1;
                if (r_pend == PEND_W'(1)) begin
                    w_args  = args_inc;
                    w_phase = PH_START;
                end
            end
            PH_ESC: begin
                w_args  = '0;
                w_phase = PH_START;
            end
            PH_MASK: begin
                if (r_pend != '0) begin
                    w_pend = r_pend - 1'b1;
                end
                if (r_pend <= PEND_W'(1)) begin
                    w_phase = PH_START;
                end
            end
            default: begin
                w_phase = PH_START;
            end
        endcase

        if (end_glyph) begin
            n_phase = PH_START;
            n_pend  = '0;
            n_coll  = '0;
            n_lead  = '0;
            n_stems = '0;
            n_args  = '0;
            n_lsn   = '0;
        end else begin
            n_phase = w_phase;
            n_pend  = w_pend;
            n_coll  = w_coll;
            n_lead  = w_lead;
            n_stems = w_stems;
            n_args  = w_args;
            n_lsn   = w_lsn;
        end
    end

    // result
    always_comb begin
        res_valid = 1'b1;
        res_kind  = KIND_OPERATOR;
        res_value = {24'd0, b};
        res_fixed = 1'b0;
        lead_off  = (r_lead >= NUM_NEG_LO) ? 2'(r_lead - NUM_NEG_LO) : 2'(r_lead - NUM_POS_LO);
        mag       = NUM_OFFSET + {1'b0, lead_off, b};
        unique case (r_phase)
            PH_START: begin
                if (i_item.cls == CLS_LEAD || i_item.cls == CLS_ESC) begin
                    res_valid = 1'b0;
                end else if (i_item.cls == CLS_SMALL) begin
                    res_kind  = KIND_NUMBER;
                    res_value = 32'(i_item.small_val);
                end
            end
            PH_NUM: begin
                res_valid = (r_pend == PEND_W'(1));
                res_kind  = KIND_NUMBER;
                if (r_lead == OP_SHORTINT) begin
                    res_value = {{16{shift_coll[15]}}, shift_coll[15:0]};
                end else if (r_lead == NUM_LONG) begin
                    res_value = shift_coll;
                    res_fixed = !i_type1_numbers;
                end else if (r_lead < NUM_NEG_LO) begin
                    res_value = {21'd0, mag};
                end else begin
                    res_value = -{21'd0, mag};
                end
            end
            PH_ESC: begin
                res_kind = i_item.esc_known ? KIND_ESCAPED : KIND_UNKNOWN;
            end
            PH_MASK: begin
                res_kind = KIND_MASK;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
        if (i_item.last && w_phase != PH_START) begin
            res_valid = 1'b1;
            res_kind  = KIND_TRUNC;
            res_value = {24'd0, w_lead};
            res_fixed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_pend      <= '0;
            r_coll      <= '0;
            r_lead      <= '0;
            r_stems     <= '0;
            r_args      <= '0;
            r_lsn       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_pend  <= n_pend;
                r_coll  <= n_coll;
                r_lead  <= n_lead;
                r_stems <= n_stems;
                r_args  <= n_args;
                r_lsn   <= n_lsn;
            end
            if (advance) begin
                r_out_valid <= o_pop && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && res_valid) begin
            r_kind     <= res_kind;
            r_value    <= res_value;
            r_fixed    <= res_fixed;
            r_stem_out <= 7'(w_stems);
            r_end      <= end_glyph;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_stem_out, r_value};
    assign o_m_tuser  = {r_fixed, r_kind};
    assign o_m_tlast  = r_end;

endmodule

FILE: hw/rtl/charstring_token_parser_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Carries                                    Item taken when
// s_*      in   tdata[7:0] byte, tlast final byte          s_tvalid & s_tready
// m_*      out  tdata value/stem count, tuser kind/fixed   m_tvalid & m_tready
// APB      in   master_count, type1_numbers, stop_at_endchar  psel & penable & pwrite
//
// One byte per cycle sustained while the output is not stalled; each byte passes through
// the four-entry queue, then the parser stage and its output register.
// Reset is synchronous; it clears the queue, the parser state and the registers.
// A stalled output holds the parser; the queue keeps taking bytes until full.
module charstring_token_parser_unit #(
    parameter int MAX_STEMS = cstp_pkg::MAX_STEMS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] data_byte
    input  logic                        i_s_tlast,   // last_byte
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [39:0]                 o_m_tdata,   // [31:0] token_value, [38:32] stem_count
    output logic [3:0]                  o_m_tuser,   // [2:0] token_kind, [3] is_fixed
    output logic                        o_m_tlast,   // end_of_glyph
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [cstp_pkg::APB_AW-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_pready
);
    import cstp_pkg::*;

    logic [4:0] r_masters;
    logic       r_type1;
    logic       r_stop;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    t_cls_item  front_item;
    t_cls_item  q_item;
    logic       push;
    logic       q_full;
    logic       q_valid;
    logic       pop;

    assign o_pready = 1'b1;
    assign reg_idx  = i_paddr[3:2];
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masters <= 5'd1;
            r_type1   <= 1'b0;
            r_stop    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MASTER_COUNT:    r_masters <= i_pwdata[4:0];
                REG_TYPE1_NUMBERS:   r_type1   <= i_pwdata[0];
                REG_STOP_AT_ENDCHAR: r_stop    <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MASTER_COUNT:    o_prdata = {27'd0, r_masters};
            REG_TYPE1_NUMBERS:   o_prdata = {31'd0, r_type1};
            REG_STOP_AT_ENDCHAR: o_prdata = {31'd0, r_stop};
            default:             o_prdata = 32'd0;
        endcase
    end

    cstp_front u_front (
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_item     (front_item)
    );

    cstp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (q_item)
    );

    cstp_back #(
        .MAX_STEMS (MAX_STEMS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (q_valid),
        .i_item            (q_item),
        .o_pop             (pop),
        .i_master_count    (r_masters),
        .i_type1_numbers   (r_type1),
        .i_stop_at_endchar (r_stop),
        .o_m_tvalid        (o_m_tvalid),
        .i_m_tready        (i_m_tready),
        .o_m_tdata         (o_m_tdata),
        .o_m_tuser         (o_m_tuser),
        .o_m_tlast         (o_m_tlast)
    );

endmodule

FILE: verif/charstring_token_parser_unit_tb.sv
`timescale 1ns / 1ps
module charstring_token_parser_unit_tb;
    import cstp_pkg::*;

    localparam int STEM_CAP     = MAX_STEMS_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int N_PHASES     = 5;
    localparam int PHASE_ITEMS  = 80;
    localparam int MAX_REPORTS  = 10;

    // register settings per phase, phase 0 in the low bits
    localparam logic [24:0] MASTERS_BY_PHASE = {5'd3, 5'd31, 5'd0, 5'd16, 5'd1};
    localparam logic [4:0]  TYPE1_BY_PHASE   = 5'b11010;
    localparam logic [4:0]  STOP_BY_PHASE    = 5'b10110;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic        fixed;
        logic [6:0]  stems;
        logic        eog;
    } t_token;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         typed;
        t_token     tok;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata = '0;
    logic                i_s_tlast = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [39:0]         o_m_tdata;
    logic [3:0]          o_m_tuser;
    logic                o_m_tlast;
    logic                i_psel = 1'b0;
    logic                i_penable = 1'b0;
    logic                i_pwrite = 1'b0;
    logic [APB_AW-1:0]   i_paddr = '0;
    logic [31:0]         i_pwdata = '0;
    logic [31:0]         o_prdata;
    logic                o_pready;

    charstring_token_parser_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_token   token_q[$];
    t_dir_row dir_rows[$];
    int       n_err = 0;
    int       cycle_cnt = 0;
    bit       snd_burst = 0;
    int       arg_run = 0;

    // parser mirror
    t_phase      ps_phase = PH_START;
    logic [3:0]  ps_pending = '0;
    logic [31:0] ps_word = '0;
    logic [7:0]  ps_lead = '0;
    int          ps_stems = 0;
    int          ps_args = 0;
    int          ps_last_small = 0;
    logic [4:0]  cfg_masters = 5'd1;
    logic        cfg_type1 = 1'b0;
    logic        cfg_stop = 1'b0;

    function automatic void clear_glyph_state();
        ps_phase      = PH_START;
        ps_pending    = '0;
        ps_word       = '0;
        ps_lead       = '0;
        ps_stems      = 0;
        ps_args       = 0;
        ps_last_small = 0;
    endfunction

    function automatic void bump_args();
        if (ps_args < 32767) ps_args++;
    endfunction

    function automatic void absorb_stems();
        if (ps_args > 0) begin
            ps_stems = ps_stems + ps_args / 2;
            if (ps_stems > STEM_CAP) ps_stems = STEM_CAP;
        end
        ps_args = 0;
    endfunction

    function automatic t_token make_token(t_kind k, logic [31:0] v, logic fx);
        t_token t;
        t.kind  = k;
        t.value = v;
        t.fixed = fx;
        t.stems = ps_stems[6:0];
        t.eog   = 1'b0;
        return t;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic l,
                                       output bit got, output t_token tok);
        bit          glyph_done;
        int          k;
        int          m;
        logic [31:0] v;
        logic        fx;
        glyph_done = 0;
        got = 0;
        tok = '0;
        case (ps_phase)
            PH_START: begin
                if (b >= NUM_SMALL_LO && b <= NUM_SMALL_HI) begin
                    ps_last_small = int'(b) - int'(NUM_BIAS);
                    bump_args();
                    tok = make_token(KIND_NUMBER, ps_last_small, 1'b0);
                    got = 1;
                end else if (b >= NUM_POS_LO) begin
                    ps_lead    = b;
                    ps_word    = '0;
                    ps_pending = (b == NUM_LONG) ? 4'd4 : 4'd1;
                    ps_phase   = PH_NUM;
                end else if (b == OP_SHORTINT) begin
                    ps_lead    = b;
                    ps_word    = '0;
                    ps_pending = 4'd2;
                    ps_phase   = PH_NUM;
                end else if (b == OP_ESCAPE) begin
                    ps_lead  = OP_ESCAPE;
                    ps_phase = PH_ESC;
                end else if (b == OP_HINTMASK || b == OP_CNTRMASK) begin
                    absorb_stems();
                    k = (ps_stems + 7) / 8;
                    tok = make_token(KIND_OPERATOR, {24'd0, b}, 1'b0);
                    got = 1;
                    if (k > 0) begin
                        ps_lead    = b;
                        ps_pending = k[3:0];
                        ps_phase   = PH_MASK;
                    end
                end else if (b == OP_BLEND) begin
                    m = (cfg_masters == 0) ? 1 : int'(cfg_masters);
                    ps_args = ps_args - (ps_last_small * (m - 1) + 1);
                    if (ps_args < -32768) ps_args = -32768;
                    if (ps_args > 32767) ps_args = 32767;
                    tok = make_token(KIND_OPERATOR, {24'd0, b}, 1'b0);
                    got = 1;
                end else if (b == OP_ENDCHAR) begin
                    tok = make_token(KIND_OPERATOR, {24'd0, b}, 1'b0);
                    got = 1;
                    if (cfg_stop) glyph_done = 1;
                end else if (b == OP_HSTEM || b == OP_VSTEM || b == OP_HSTEMHM ||
                             b == OP_VSTEMHM) begin
                    absorb_stems();
                    tok = make_token(KIND_OPERATOR, {24'd0, b}, 1'b0);
                    got = 1;
                end else begin
                    ps_args = 0;
                    tok = make_token(KIND_OPERATOR, {24'd0, b}, 1'b0);
                    got = 1;
                end
            end
            PH_NUM: begin
                ps_word    = {ps_word[23:0], b};
                ps_pending = ps_pending - 4'd1;
                if (ps_pending == 0) begin
                    fx = 1'b0;
                    if (ps_lead == OP_SHORTINT) begin
                        v = {{16{ps_word[15]}}, ps_word[15:0]};
                    end else if (ps_lead == NUM_LONG) begin
                        v  = ps_word;
                        fx = !cfg_type1;
                    end else if (ps_lead < NUM_NEG_LO) begin
                        v = int'(NUM_OFFSET) + 256 * (int'(ps_lead) - int'(NUM_POS_LO))
                            + int'(ps_word[7:0]);
                    end else begin
                        v = -int'(NUM_OFFSET) - 256 * (int'(ps_lead) - int'(NUM_NEG_LO))
                            - int'(ps_word[7:0]);
                    end
                    bump_args();
                    ps_phase = PH_START;
                    tok = make_token(KIND_NUMBER, v, fx);
                    got = 1;
                end
            end
            PH_ESC: begin
                ps_args  = 0;
                ps_phase = PH_START;
                tok = make_token((b <= ESC_MAX) ? KIND_ESCAPED : KIND_UNKNOWN,
                                 {24'd0, b}, 1'b0);
                got = 1;
            end
            default: begin
                tok = make_token(KIND_MASK, {24'd0, b}, 1'b0);
                got = 1;
                if (ps_pending > 0) ps_pending = ps_pending - 4'd1;
                if (ps_pending == 0) ps_phase = PH_START;
            end
        endcase
        if (l) begin
            // unfinished token at the final byte
            if (ps_phase != PH_START) begin
                tok = make_token(KIND_TRUNC, {24'd0, ps_lead}, 1'b0);
                got = 1;
            end
            glyph_done = 1;
        end
        if (glyph_done) begin
            if (got) tok.eog = 1'b1;
            clear_glyph_state();
        end
    endfunction

    function automatic void add_row(logic [7:0] b, logic l, bit typed, t_kind k,
                                    logic [31:0] v, logic fx, logic eog);
        t_dir_row r;
        r.data      = b;
        r.last      = l;
        r.typed     = typed;
        r.tok.kind  = k;
        r.tok.value = v;
        r.tok.fixed = fx;
        r.tok.stems = '0;
        r.tok.eog   = eog;
        dir_rows.push_back(r);
    endfunction

    // mostly well-formed glyph content, steered by the mirror's state
    function automatic logic [7:0] pick_byte();
        int r;
        if (ps_phase == PH_ESC) begin
            if ($urandom_range(0, 3) == 0) return 8'($urandom_range(39, 255));
            return 8'($urandom_range(0, 38));
        end
        if (ps_phase != PH_START) return 8'($urandom_range(0, 255));
        if (arg_run > 0) begin
            arg_run--;
            return 8'($urandom_range(32, 246));
        end
        r = $urandom_range(0, 99);
        if (r < 35) return 8'($urandom_range(32, 246));
        if (r < 45) return 8'($urandom_range(247, 254));
        if (r < 50) return OP_SHORTINT;
        if (r < 54) return NUM_LONG;
        if (r < 60) begin
            arg_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 220)
                                                  : $urandom_range(1, 12);
            return 8'($urandom_range(32, 246));
        end
        if (r < 70) begin
            case ($urandom_range(0, 3))
                0: return OP_HSTEM;
                1: return OP_VSTEM;
                2: return OP_HSTEMHM;
                default: return OP_VSTEMHM;
            endcase
        end
        if (r < 77) return ($urandom_range(0, 1) == 0) ? OP_HINTMASK : OP_CNTRMASK;
        if (r < 81) return OP_BLEND;
        if (r < 84) return OP_ENDCHAR;
        if (r < 90) return OP_ESCAPE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                             input t_token typed_tok);
        int     gap;
        bit     got;
        t_token tok;
        if ($urandom_range(0, 29) == 0) snd_burst = !snd_burst;
        gap = snd_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= l;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        parse_byte(b, l, got, tok);
        if (typed) token_q.push_back(typed_tok);
        else if (got) token_q.push_back(tok);
    endtask

    // hold off until every token is out and the block has gone quiet
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (token_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        case (idx)
            REG_MASTER_COUNT:    cfg_masters = val[4:0];
            REG_TYPE1_NUMBERS:   cfg_type1   = val[0];
            REG_STOP_AT_ENDCHAR: cfg_stop    = val[0];
            default: ;
        endcase
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // token sink
    initial begin
        int     gap;
        bit     rcv_burst;
        t_token got;
        t_token exp;
        rcv_burst = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) rcv_burst = !rcv_burst;
            gap = rcv_burst ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            got.kind  = t_kind'(o_m_tuser[2:0]);
            got.value = o_m_tdata[31:0];
            got.fixed = o_m_tuser[3];
            got.stems = o_m_tdata[38:32];
            got.eog   = o_m_tlast;
            if (token_q.size() == 0) begin
                n_err++;
                if (n_err <= MAX_REPORTS)
                    $display("unexpected token: kind %0d value %08h", got.kind, got.value);
            end else begin
                exp = token_q.pop_front();
                if (got !== exp) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display({"token mismatch: exp kind %0d value %08h fixed %0b ",
                                  "stems %0d end %0b / got kind %0d value %08h fixed %0b ",
                                  "stems %0d end %0b"},
                                 exp.kind, exp.value, exp.fixed, exp.stems, exp.eog,
                                 got.kind, got.value, got.fixed, got.stems, got.eog);
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int         ph;
        int         n;
        logic [7:0] b;
        logic       l;
        // numbers at their extremes, escapes and a truncation, all at reset settings
        add_row(8'd32,  1'b0, 1, KIND_NUMBER,  -32'sd107,    1'b0, 1'b0);
        add_row(8'd246, 1'b0, 1, KIND_NUMBER,  32'd107,      1'b0, 1'b0);
        add_row(8'd247, 1'b0, 0, KIND_NUMBER,  '0,           1'b0, 1'b0);
        add_row(8'd0,   1'b0, 1, KIND_NUMBER,  32'd108,      1'b0, 1'b0);
        add_row(8'd254, 1'b0, 0, KIND_NUMBER,  '0,           1'b0, 1'b0);
        add_row(8'd255, 1'b0, 1, KIND_NUMBER,  -32'sd1131,   1'b0, 1'b0);
        add_row(8'd28,  1'b0, 0, KIND_NUMBER,  '0,           1'b0, 1'b0);
        add_row(8'h80,  1'b0, 0, KIND_NUMBER,  '0,           1'b0, 1'b0);
        add_row(8'h00,  1'b0, 1, KIND_NUMBER,  -32'sd32768,  1'b0, 1'b0);
        add_row(8'd255, 1'b0, 0, KIND_NUMBER,  '0,           1'b0, 1'b0);
        add_row(8'h7f,  1'b0, 0, KIND_NUMBER,  '0,           1'b0, 1'b0);
        add_row(8'hff,  1'b0, 0, KIND_NUMBER,  '0,           1'b0, 1'b0);
        add_row(8'hff,  1'b0, 0, KIND_NUMBER,  '0,           1'b0, 1'b0);
        add_row(8'hff,  1'b0, 1, KIND_NUMBER,  32'h7fffffff, 1'b1, 1'b0);
        add_row(8'd12,  1'b0, 0, KIND_NUMBER,  '0,           1'b0, 1'b0);
        add_row(8'd38,  1'b0, 1, KIND_ESCAPED, 32'd38,       1'b0, 1'b0);
        add_row(8'd12,  1'b0, 0, KIND_NUMBER,  '0,           1'b0, 1'b0);
        add_row(8'd255, 1'b0, 1, KIND_UNKNOWN, 32'd255,      1'b0, 1'b0);
        add_row(8'd28,  1'b1, 1, KIND_TRUNC,   32'd28,       1'b0, 1'b1);
        // stems, hint mask, blend, endchar, unfinished counter mask
        add_row(8'd246, 1'b0, 0, KIND_NUMBER,  '0,           1'b0, 1'b0);
        add_row(8'd246, 1'b0, 0, KIND_NUMBER,  '0,           1'b0, 1'b0);
        add_row(OP_VSTEMHM,  1'b0, 0, KIND_NUMBER, '0, 1'b0, 1'b0);
        add_row(OP_HINTMASK, 1'b0, 0, KIND_NUMBER, '0, 1'b0, 1'b0);
        add_row(8'hff,  1'b0, 0, KIND_NUMBER,  '0,           1'b0, 1'b0);
        add_row(OP_BLEND,    1'b0, 0, KIND_NUMBER, '0, 1'b0, 1'b0);
        add_row(OP_ENDCHAR,  1'b0, 0, KIND_NUMBER, '0, 1'b0, 1'b0);
        add_row(OP_CNTRMASK, 1'b1, 0, KIND_NUMBER, '0, 1'b0, 1'b0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n])
            send_byte(dir_rows[n].data, dir_rows[n].last, dir_rows[n].typed, dir_rows[n].tok);

        for (ph = 0; ph < N_PHASES; ph++) begin
            settle();
            reg_write(REG_MASTER_COUNT, {27'd0, MASTERS_BY_PHASE[ph*5 +: 5]});
            reg_write(REG_TYPE1_NUMBERS, {31'd0, TYPE1_BY_PHASE[ph]});
            reg_write(REG_STOP_AT_ENDCHAR, {31'd0, STOP_BY_PHASE[ph]});
            for (n = 0; n < PHASE_ITEMS; n++) begin
                b = pick_byte();
                l = ($urandom_range(0, 49) == 0);
                send_byte(b, l, 0, '0);
            end
        end

        settle();
        if (token_q.size() != 0) begin
            $display("%0d expected tokens never arrived", token_q.size());
            n_err += token_q.size();
        end
        if (n_err == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
